FILE: hdl/hcb_pkg.sv
package hcb_pkg;

  // key matrix and block geometry
  localparam int KEY_DIM   = 4;
  localparam int VAL_W     = 5;
  localparam int IDX_W     = 2;
  localparam int ORDER_W   = 3;
  localparam int KEY_W     = KEY_DIM * VAL_W;
  localparam int LETTER_W  = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KEY_W;

  // mod 26 arithmetic: sum of four 5x5 products fits in 12 bits
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 16;
  localparam int QUO_W       = SUM_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP   = 12'd2521;
  localparam logic [SUM_W-1:0]   MODULUS = 12'd26;

  // alphabet
  localparam logic [LETTER_W-1:0] ASCII_LC_A  = 8'h61;
  localparam logic [LETTER_W-1:0] ASCII_UC_A  = 8'h41;
  localparam logic [LETTER_W-1:0] ALPHA_SPAN  = 8'd25;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER     = 3'd0,
    CFG_MODE      = 3'd1,
    CFG_KEY_ROW_0 = 3'd2,
    CFG_KEY_ROW_1 = 3'd3,
    CFG_KEY_ROW_2 = 3'd4,
    CFG_KEY_ROW_3 = 3'd5
  } cfg_reg_t;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;

  typedef logic [VAL_W-1:0] val_t;
  typedef val_t [KEY_DIM-1:0] block_t;
  typedef logic [KEY_DIM-1:0][KEY_W-1:0] key_rows_t;

  // identity matrix
  localparam key_rows_t KEY_RESET = {20'd32768, 20'd1024, 20'd32, 20'd1};

  // one block job or one error job
  typedef struct packed {
    block_t             vals;
    logic [ORDER_W-1:0] ord;
    logic               decrypt;
    logic               bad;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

endpackage

FILE: hdl/hcb_in_if.sv
interface hcb_in_if
  import hcb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] letter;
  logic                message_end;

  modport source (output valid, output letter, output message_end, input ready);
  modport sink (input valid, input letter, input message_end, output ready);
endinterface

FILE: hdl/hcb_out_if.sv
interface hcb_out_if
  import hcb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] out_letter;
  logic                block_last;
  logic                bad_input;

  modport source (output valid, output out_letter, output block_last, output bad_input,
                  input ready);
  modport sink (input valid, input out_letter, input block_last, input bad_input,
                output ready);
endinterface

FILE: hdl/hill_cipher_block_unit.sv
// Hill cipher, mod 26, one ASCII character per transaction.
// in_ch carries letter and message_end; out_ch carries out_letter, block_last
// and bad_input. Both use valid/ready; a transaction moves when both are high.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata: 0 order, 1 mode,
// 2..5 key rows (inverse matrix for decrypt); write only while idle.
// Throughput: one input transaction per cycle while the queue has room, and one
// result per cycle unless out_ch stalls, from a row sequencer feeding a
// three-stage dot product / mod 26 pipeline. The first letter of a block goes
// from the queue through the stage 1, stage 2 and output registers to out_ch;
// the rest follow one per cycle while out_ch is ready. A bad letter gives one
// error result (letter 0, block_last and bad_input set) the same way, then
// letters are swallowed until message_end. A two-entry job queue sits between
// the letter front end and the result pipeline; when out_ch stalls the pipeline
// holds, the queue fills and in_ch.ready drops. Reset (rst_n low, synchronous)
// empties the queue and the pipeline, clears the partial block and error latch,
// and loads order 2, encrypt mode and the identity key.
module hill_cipher_block_unit
  import hcb_pkg::*;
#(
  parameter int MAX_ORDER = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hcb_in_if.sink                in_ch,
  hcb_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ORDER_LIM = (MAX_ORDER < KEY_DIM) ? MAX_ORDER : KEY_DIM;

  logic [ORDER_W-1:0] order_r;
  logic               decrypt_r;
  key_rows_t          key_rows_r;
  logic [ORDER_W-1:0] ord_eff;

  q_push_t push;
  q_head_t head;
  logic    pop, q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r    <= ORDER_RESET;
      decrypt_r  <= 1'b0;
      key_rows_r <= KEY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_ORDER:     order_r       <= cfg_wdata[ORDER_W-1:0];
        CFG_MODE:      decrypt_r     <= cfg_wdata[0];
        CFG_KEY_ROW_0: key_rows_r[0] <= cfg_wdata[KEY_W-1:0];
        CFG_KEY_ROW_1: key_rows_r[1] <= cfg_wdata[KEY_W-1:0];
        CFG_KEY_ROW_2: key_rows_r[2] <= cfg_wdata[KEY_W-1:0];
        CFG_KEY_ROW_3: key_rows_r[3] <= cfg_wdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp order into 1..limit
  always_comb begin
    if (order_r == '0) begin
      ord_eff = ORDER_W'(1);
    end else if (order_r > ORDER_W'(ORDER_LIM)) begin
      ord_eff = ORDER_W'(ORDER_LIM);
    end else begin
      ord_eff = order_r;
    end
  end

  hcb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .ord_eff (ord_eff),
    .decrypt (decrypt_r),
    .q_full  (q_full),
    .push    (push)
  );

  hcb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  hcb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .key_rows (key_rows_r),
    .out_ch   (out_ch)
  );

  // a job is never raised into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> !q_full)
    else $error("job raised while queue full");

  // error results carry a zero letter and close their block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bad_input |-> out_ch.block_last && (out_ch.out_letter == '0))
    else $error("malformed error result");

  // normal results are always letters of the alphabet
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.bad_input |->
      ((out_ch.out_letter >= ASCII_UC_A) && (out_ch.out_letter <= ASCII_UC_A + ALPHA_SPAN)) ||
      ((out_ch.out_letter >= ASCII_LC_A) && (out_ch.out_letter <= ASCII_LC_A + ALPHA_SPAN)))
    else $error("result letter outside alphabet");

  // a pop only happens when the queue holds a job
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

FILE: hdl/hcb_front.sv
module hcb_front
  import hcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  hcb_in_if.sink             in_ch,
  input  logic [ORDER_W-1:0] ord_eff,
  input  logic               decrypt,
  input  logic               q_full,
  output q_push_t            push
);

  block_t             blk_r, blk_nxt;
  logic [ORDER_W-1:0] fill_r, fill_nxt;
  logic               bad_r, bad_nxt;

  logic                accept;
  logic [LETTER_W-1:0] in_base;
  logic [LETTER_W-1:0] offset;
  logic                letter_ok;
  logic [ORDER_W-1:0]  fill_inc;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // classify the letter against the expected case
  always_comb begin
    in_base   = decrypt ? ASCII_UC_A : ASCII_LC_A;
    offset    = in_ch.letter - in_base;
    letter_ok = (in_ch.letter >= in_base) && (in_ch.letter <= in_base + ALPHA_SPAN);
    fill_inc  = fill_r + ORDER_W'(1);
  end

  // collect block, raise jobs, track error latch
  always_comb begin
    blk_nxt          = blk_r;
    fill_nxt         = fill_r;
    bad_nxt          = bad_r;
    push.valid       = 1'b0;
    push.job.vals    = blk_r;
    push.job.ord     = ord_eff;
    push.job.decrypt = decrypt;
    push.job.bad     = 1'b0;
    if (accept) begin
      if (!bad_r) begin
        if (!letter_ok) begin
          push.valid   = 1'b1;
          push.job.bad = 1'b1;
          bad_nxt      = 1'b1;
          fill_nxt     = '0;
        end else begin
          blk_nxt[fill_r[IDX_W-1:0]] = offset[VAL_W-1:0];
          push.job.vals              = blk_nxt;
          if (fill_inc >= ord_eff) begin
            push.valid = 1'b1;
            fill_nxt   = '0;
          end else begin
            fill_nxt = fill_inc;
          end
        end
      end
      // end of message drops a partial block and clears the latch
      if (in_ch.message_end) begin
        bad_nxt  = 1'b0;
        fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bad_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      bad_r  <= bad_nxt;
    end
  end

  // block payload
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

FILE: hdl/hcb_queue.sv
module hcb_queue
  import hcb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  input  logic    pop,
  output q_head_t head,
  output logic    full
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

FILE: hdl/hcb_back.sv
module hcb_back
  import hcb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      pop,
  input  key_rows_t key_rows,
  hcb_out_if.source out_ch
);

  logic [IDX_W-1:0] row_r, row_nxt;
  logic             issue, row_last;
  logic [SUM_W-1:0] dot_sum;
  logic [KEY_W-1:0] key_row;

  // stage 1: dot product
  logic             s1_valid_r;
  logic [SUM_W-1:0] s1_sum_r;
  logic             s1_last_r, s1_bad_r, s1_dec_r;
  // stage 2: quotient estimate
  logic             s2_valid_r;
  logic [SUM_W-1:0] s2_sum_r;
  logic [QUO_W-1:0] s2_quo_r;
  logic             s2_last_r, s2_bad_r, s2_dec_r;
  // stage 3: output register
  logic                out_valid_r;
  logic [LETTER_W-1:0] out_letter_r;
  logic                out_last_r, out_bad_r;

  logic s1_en, s2_en, s3_en;
  logic [SUM_W+RECIP_W-1:0] recip_prod;
  logic [SUM_W-1:0]         quo_ext, rem_full;
  logic [LETTER_W-1:0]      letter_calc;

  // stall chain from the output backwards
  assign s3_en = !out_valid_r || out_ch.ready;
  assign s2_en = !s2_valid_r || s3_en;
  assign s1_en = !s1_valid_r || s2_en;

  // row sequencer over the head job
  assign row_last = ({1'b0, row_r} == head.job.ord - ORDER_W'(1));
  assign issue    = head.valid && s1_en;
  assign pop      = issue && (head.job.bad || row_last);
  assign row_nxt  = pop ? '0 : (issue ? row_r + IDX_W'(1) : row_r);

  // one row of the key matrix against the block
  always_comb begin
    key_row = key_rows[row_r];
    dot_sum = '0;
    for (int c = 0; c < KEY_DIM; c++) begin
      if (ORDER_W'(c) < head.job.ord) begin
        dot_sum = dot_sum + SUM_W'(key_row[c*VAL_W +: VAL_W]) * SUM_W'(head.job.vals[c]);
      end
    end
  end

  // mod 26 by reciprocal, exact for sums below 4096
  always_comb begin
    recip_prod  = SUM_W'(s1_sum_r) * (SUM_W + RECIP_W)'(RECIP);
    quo_ext     = SUM_W'(s2_quo_r);
    rem_full    = s2_sum_r - quo_ext * MODULUS;
    letter_calc = (s2_dec_r ? ASCII_LC_A : ASCII_UC_A) + LETTER_W'(rem_full[VAL_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      if (s1_en) begin
        s1_valid_r <= issue;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_en) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_sum_r  <= dot_sum;
      s1_last_r <= head.job.bad || row_last;
      s1_bad_r  <= head.job.bad;
      s1_dec_r  <= head.job.decrypt;
    end
    if (s2_en && s1_valid_r) begin
      s2_sum_r  <= s1_sum_r;
      s2_quo_r  <= recip_prod[SUM_W+RECIP_W-1:RECIP_SHIFT];
      s2_last_r <= s1_last_r;
      s2_bad_r  <= s1_bad_r;
      s2_dec_r  <= s1_dec_r;
    end
    if (s3_en && s2_valid_r) begin
      out_letter_r <= s2_bad_r ? '0 : letter_calc;
      out_last_r   <= s2_last_r;
      out_bad_r    <= s2_bad_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_letter = out_letter_r;
  assign out_ch.block_last = out_last_r;
  assign out_ch.bad_input  = out_bad_r;

endmodule
